[hdl/utf8_brace_hex_escape_encoder_core_macros.svh]
// assertion helpers shared by the encoder modules
`ifndef UTF8_BRACE_HEX_ESCAPE_ENCODER_CORE_MACROS_SVH
`define UTF8_BRACE_HEX_ESCAPE_ENCODER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define UBE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define UBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ube_pkg.sv]
`timescale 1ns / 1ps
package ube_pkg;

    localparam logic [7:0] C_ASCII_MAX  = 8'h7F;
    localparam logic [7:0] C_SPACE      = 8'h20;
    localparam logic [7:0] C_LBRACE     = 8'h7B;
    localparam logic [7:0] C_RBRACE     = 8'h7D;
    localparam logic [7:0] C_MASK2      = 8'hE0;
    localparam logic [7:0] C_LEAD2      = 8'hC0;
    localparam logic [7:0] C_MASK3      = 8'hF0;
    localparam logic [7:0] C_LEAD3      = 8'hE0;
    localparam logic [7:0] C_MASK4      = 8'hF8;
    localparam logic [7:0] C_LEAD4      = 8'hF0;
    localparam logic [7:0] C_CONT_MASK  = 8'hC0;
    localparam logic [7:0] C_CONT       = 8'h80;

    localparam int QDEPTH = 4;
    localparam int BUFLEN = 4;

    typedef enum logic [1:0] {
        K_LIT   = 2'd0,
        K_BRACE = 2'd1,
        K_HEX   = 2'd2,
        K_MB    = 2'd3
    } t_kind;

    // one classified unit of the string
    typedef struct packed {
        t_kind            kind;
        logic [3:0][7:0]  bytes;
        logic [2:0]       len;
        logic             last;
    } t_tok;

    typedef struct packed {
        logic push;
        t_tok tok;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_tok tok;
    } t_q_rd;

    // expected length of a character from its lead byte, zero for a bad lead
    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] l;
        if (c <= C_ASCII_MAX)                 l = 3'd1;
        else if ((c & C_MASK2) == C_LEAD2)    l = 3'd2;
        else if ((c & C_MASK3) == C_LEAD3)    l = 3'd3;
        else if ((c & C_MASK4) == C_LEAD4)    l = 3'd4;
        else                                  l = 3'd0;
        return l;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10) d = 8'h30 + {4'h0, n};
        else           d = 8'h37 + {4'h0, n};
        return d;
    endfunction

endpackage

[hdl/ube_if.sv]
`timescale 1ns / 1ps
interface ube_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ube_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

[hdl/ube_front.sv]
`timescale 1ns / 1ps
`include "utf8_brace_hex_escape_encoder_core_macros.svh"
module ube_front import ube_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ube_in_if.sink i_in,
    output t_q_wr  o_wr,
    input  logic   i_full
);

    logic [3:0][7:0] r_buf, n_buf;
    logic [2:0]      r_cnt, n_cnt;
    logic            r_last, n_last;

    logic [7:0]      c;
    logic [2:0]      len;
    logic            bad;
    logic            tok_ok;
    logic            hold;
    logic [2:0]      consumed;
    t_kind           kind;
    logic            pop;
    logic            rdy;
    logic            acc;
    logic [2:0]      keep;
    logic [2:0]      idx;
    logic [3:0][7:0] sh;

    always_comb begin
        c   = r_buf[0];
        len = lead_length(c);
        bad = 1'b0;
        for (int j = 1; j < BUFLEN; j++) begin
            if (3'(j) < len && 3'(j) < r_cnt && (r_buf[j] & C_CONT_MASK) != C_CONT) begin
                bad = 1'b1;
            end
        end

        tok_ok   = 1'b0;
        hold     = 1'b0;
        consumed = 3'd1;
        kind     = K_HEX;
        if (r_cnt != 3'd0) begin
            if (len >= 3'd2) begin
                if (!bad && r_cnt >= len) begin
                    kind     = K_MB;
                    consumed = len;
                    tok_ok   = 1'b1;
                end else if (!bad && !r_last) begin
                    // lead still missing continuation words
                    hold = 1'b1;
                end else begin
                    tok_ok = 1'b1;
                end
            end else if (len == 3'd1 && c >= C_SPACE && c != C_ASCII_MAX) begin
                kind   = (c == C_LBRACE) ? K_BRACE : K_LIT;
                tok_ok = 1'b1;
            end else begin
                tok_ok = 1'b1;
            end
        end

        pop = tok_ok && !i_full;
        rdy = (r_cnt == 3'd0) || hold || (pop && consumed == r_cnt);
        acc = i_in.valid && rdy;

        for (int i = 0; i < BUFLEN; i++) begin
            idx   = 3'(i) + consumed;
            sh[i] = (idx < 3'(BUFLEN)) ? r_buf[idx[1:0]] : 8'h00;
        end
        keep  = pop ? (r_cnt - consumed) : r_cnt;
        n_buf = pop ? sh : r_buf;
        if (acc) begin
            n_buf[keep[1:0]] = i_in.in_byte;
        end
        n_cnt  = keep + {2'b00, acc};
        n_last = acc ? i_in.in_last : ((n_cnt == 3'd0) ? 1'b0 : r_last);
    end

    assign i_in.ready     = rdy;
    assign o_wr.push      = pop;
    assign o_wr.tok.kind  = kind;
    assign o_wr.tok.bytes = r_buf;
    assign o_wr.tok.len   = len;
    assign o_wr.tok.last  = r_last && (consumed == r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 3'd0;
            r_last <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    `UBE_ASSERT_IMPL(a_cnt_range, 1'b1, r_cnt <= 3'(BUFLEN), "lookahead count out of range")
    `UBE_ASSERT_IMPL(a_hold_no_last, hold, !r_last, "waiting on a string that has ended")

endmodule

[hdl/ube_fifo.sv]
`timescale 1ns / 1ps
`include "utf8_brace_hex_escape_encoder_core_macros.svh"
module ube_fifo import ube_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_full,
    output t_q_rd o_rd,
    input  logic  i_pop
);

    t_tok       r_mem [QDEPTH];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       do_pop;

    assign o_full   = (r_cnt == 3'(QDEPTH));
    assign o_rd.valid = (r_cnt != 3'd0);
    assign o_rd.tok   = r_mem[r_rp];
    assign do_pop   = i_pop && o_rd.valid;

    always_comb begin
        n_wp  = i_wr.push ? r_wp + 2'd1 : r_wp;
        n_rp  = do_pop ? r_rp + 2'd1 : r_rp;
        n_cnt = r_cnt + {2'b00, i_wr.push} - {2'b00, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wp] <= i_wr.tok;
        end
    end

    `UBE_ASSERT_IMPL(a_no_overflow, o_full, !i_wr.push, "push into a full queue")
    `UBE_ASSERT_NEXT(a_fill_up, i_wr.push && !do_pop, r_cnt == $past(r_cnt) + 3'd1, "lost push")

endmodule

[hdl/ube_back.sv]
`timescale 1ns / 1ps
`include "utf8_brace_hex_escape_encoder_core_macros.svh"
module ube_back import ube_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_rd      i_rd,
    output logic       o_pop,
    ube_out_if.source  o_out
);

    logic [2:0] r_step, n_step;
    logic       r_open, n_open;
    logic       r_valid, n_valid;
    logic [7:0] r_char, n_char;
    logic       r_olast, n_olast;

    logic [7:0] seq [8];
    logic [2:0] seq_len;
    logic       ld;
    logic       fin;

    // characters produced by the head unit, given the run state at its start
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            seq[i] = 8'h00;
        end
        seq_len = 3'd0;
        if (i_rd.tok.kind != K_HEX && r_open) begin
            seq[seq_len] = C_RBRACE;
            seq_len      = seq_len + 3'd1;
        end
        case (i_rd.tok.kind)
            K_LIT: begin
                seq[seq_len] = i_rd.tok.bytes[0];
                seq_len      = seq_len + 3'd1;
            end
            K_BRACE: begin
                seq[seq_len]        = C_LBRACE;
                seq[seq_len + 3'd1] = C_LBRACE;
                seq_len             = seq_len + 3'd2;
            end
            K_MB: begin
                for (int j = 0; j < BUFLEN; j++) begin
                    if (3'(j) < i_rd.tok.len) begin
                        seq[seq_len] = i_rd.tok.bytes[j];
                        seq_len      = seq_len + 3'd1;
                    end
                end
            end
            K_HEX: begin
                if (!r_open) begin
                    seq[seq_len] = C_LBRACE;
                    seq_len      = seq_len + 3'd1;
                end
                seq[seq_len]        = hex_digit(i_rd.tok.bytes[0][7:4]);
                seq[seq_len + 3'd1] = hex_digit(i_rd.tok.bytes[0][3:0]);
                seq_len             = seq_len + 3'd2;
                if (i_rd.tok.last) begin
                    seq[seq_len] = C_RBRACE;
                    seq_len      = seq_len + 3'd1;
                end
            end
            default: begin
                seq_len = 3'd1;
            end
        endcase
    end

    always_comb begin
        ld      = i_rd.valid && (!r_valid || o_out.ready);
        fin     = (r_step == seq_len - 3'd1);
        n_step  = r_step;
        n_open  = r_open;
        n_valid = r_valid;
        n_char  = r_char;
        n_olast = r_olast;
        if (ld) begin
            n_valid = 1'b1;
            n_char  = seq[r_step];
            n_olast = i_rd.tok.last && fin;
            if (fin) begin
                n_step = 3'd0;
                n_open = (i_rd.tok.kind == K_HEX) && !i_rd.tok.last;
            end else begin
                n_step = r_step + 3'd1;
            end
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    assign o_pop          = ld && fin;
    assign o_out.valid    = r_valid;
    assign o_out.out_char = r_char;
    assign o_out.out_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_open  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_open  <= n_open;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_olast <= n_olast;
    end

    `UBE_ASSERT_IMPL(a_step_in_unit, i_rd.valid, r_step < seq_len, "step beyond unit length")
    `UBE_ASSERT_NEXT(a_end_closes_run, o_pop && i_rd.tok.last, !r_open, "run left open at end")

endmodule

[hdl/utf8_brace_hex_escape_encoder_core.sv]
`timescale 1ns / 1ps
// utf-8 brace/hex escape encoder
// i_in carries the raw string, one byte per word, in_last on the final byte.
// o_out carries the encoded string, one character per word, out_last on the
// final character of each string.
// front: a four-word lookahead buffer classifies each character (literal,
// doubled brace, complete multi-byte character, hex escape) one per cycle
// while the queue is not full. a four-entry queue parts it from the back,
// which expands each unit into its output characters, one per cycle while
// o_out is ready, into a registered output word. a byte passes the buffer,
// the queue and the output word register before its first character shows.
// throughput: one input word per cycle while the output keeps up; output is
// one character per cycle, an escaped byte costing two to four characters.
// a multi-byte lead is held in the buffer until its continuation bytes or
// the end of the string arrive.
// when o_out stalls the output word holds, the queue fills and then i_in
// ready drops; nothing is lost.
// synchronous reset empties the buffer and queue and closes any hex run.
module utf8_brace_hex_escape_encoder_core import ube_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ube_in_if.sink    i_in,
    ube_out_if.source o_out
);

    t_q_wr wr;
    t_q_rd rd;
    logic  full;
    logic  pop;

    ube_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_wr    (wr),
        .i_full  (full)
    );

    ube_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .o_rd    (rd),
        .i_pop   (pop)
    );

    ube_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[verif/tb_utf8_brace_hex_escape_encoder_core.sv]
`timescale 1ns / 1ps
module tb_utf8_brace_hex_escape_encoder_core;
    import ube_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    typedef enum int {
        TOK_PRINT  = 0,
        TOK_BRACE  = 1,
        TOK_CTRL   = 2,
        TOK_MB2    = 3,
        TOK_MB3    = 4,
        TOK_MB4    = 5,
        TOK_BROKEN = 6,
        TOK_RAW    = 7
    } t_tok_kind;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 185;
    localparam int QUIET_FROM     = DIRECTED_ITEMS + 170;
    localparam int HOLD_AT        = DIRECTED_ITEMS + 70;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 40;

    class escape_scoreboard;
        logic [7:0] held [3];
        int         held_n;
        bit         hex_open;
        logic [7:0] step_chars [$];
        t_enc_char  pending_chars [$];
        int         errors;

        function new();
            foreach (held[i]) held[i] = 8'h00;
            held_n   = 0;
            hex_open = 0;
            errors   = 0;
        endfunction

        static function int char_len(input logic [7:0] c);
            int n;
            case (c) inside
                8'b0???????: n = 1;
                8'b110?????: n = 2;
                8'b1110????: n = 3;
                8'b11110???: n = 4;
                default:     n = 0;
            endcase
            return n;
        endfunction

        static function logic [7:0] hex_char(input logic [3:0] d);
            logic [7:0] r;
            if (d < 4'd10) r = 8'h30 + {4'h0, d};
            else           r = 8'h41 + {4'h0, d} - 8'd10;
            return r;
        endfunction

        function void close_run();
            if (hex_open) begin
                step_chars.push_back(C_RBRACE);
                hex_open = 0;
            end
        endfunction

        // works out the characters that one accepted byte releases
        function void note_byte(input logic [7:0] b, input logic l);
            logic [7:0] seq [4];
            logic [7:0] c;
            int         n, pos, len, avail, j, rem;
            bit         ok;
            step_chars.delete();
            n = held_n;
            for (j = 0; j < n; j++) seq[j] = held[j];
            seq[n] = b;
            n++;
            pos = 0;
            while (pos < n) begin
                c     = seq[pos];
                len   = char_len(c);
                avail = n - pos;
                if (len >= 2) begin
                    ok = 1;
                    for (j = 1; j < len && j < avail; j++)
                        if ((seq[pos + j] & C_CONT_MASK) != C_CONT) ok = 0;
                    if (ok && avail >= len) begin
                        close_run();
                        for (j = 0; j < len; j++) step_chars.push_back(seq[pos + j]);
                        pos += len;
                        continue;
                    end
                    // lead still waiting on its continuation bytes
                    if (ok && !l) break;
                    len = 0;
                end
                if (len == 1 && c >= C_SPACE && c != C_ASCII_MAX) begin
                    close_run();
                    step_chars.push_back(c);
                    if (c == C_LBRACE) step_chars.push_back(C_LBRACE);
                end else begin
                    if (!hex_open) begin
                        step_chars.push_back(C_LBRACE);
                        hex_open = 1;
                    end
                    step_chars.push_back(hex_char(c[7:4]));
                    step_chars.push_back(hex_char(c[3:0]));
                end
                pos++;
            end
            if (l) begin
                close_run();
                held_n = 0;
                foreach (held[i]) held[i] = 8'h00;
            end else begin
                rem = n - pos;
                if (rem > 3) rem = 3;
                for (j = 0; j < rem; j++) held[j] = seq[pos + j];
                held_n = rem;
            end
            for (j = 0; j < step_chars.size(); j++)
                pending_chars.push_back('{ch: step_chars[j],
                                         last: l && (j == step_chars.size() - 1)});
        endfunction

        function void check_char(input logic [7:0] c, input logic l);
            t_enc_char want;
            if (pending_chars.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: char %h last %b", c, l);
            end else begin
                want = pending_chars.pop_front();
                if (want.ch !== c || want.last !== l) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: char %h last %b, wanted char %h last %b",
                                 c, l, want.ch, want.last);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ube_in_if  in_if ();
    ube_out_if out_if ();

    utf8_brace_hex_escape_encoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    escape_scoreboard sb = new();

    logic [7:0] str_q [$];
    int         items_sent    = 0;
    int         send_gap_pct  = 0;
    int         drain_gap_pct = 0;
    bit         quiet         = 0;
    bit         hold_req      = 0;
    bit         hold_done     = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // output side: check at the rising edge, pick ready at the falling edge
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid && out_if.ready)
                sb.check_char(out_if.out_char, out_if.out_last);
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < drain_gap_pct) begin
                stall_left = $urandom_range(1, 13) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid still up
    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
            gap = $urandom_range(1, 13);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        in_if.in_last <= l;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(b, l);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_word(str_q[i], i == str_q.size() - 1);
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] b;
        case (len)
            2:       b = {3'b110, 5'($urandom)};
            3:       b = {4'b1110, 4'($urandom)};
            default: b = {5'b11110, 3'($urandom)};
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic build_random_string();
        int         n_tok, len, pick;
        t_tok_kind  kind;
        logic [7:0] b;
        str_q.delete();
        n_tok = $urandom_range(1, 6);
        repeat (n_tok) begin
            pick = $urandom_range(0, 9);
            kind = (pick > 7) ? TOK_PRINT : t_tok_kind'(pick);
            case (kind)
                TOK_PRINT: str_q.push_back(8'($urandom_range(32, 126)));
                TOK_BRACE: str_q.push_back(C_LBRACE);
                TOK_CTRL: begin
                    if ($urandom_range(0, 7) == 0) str_q.push_back(C_ASCII_MAX);
                    else                           str_q.push_back(8'($urandom_range(0, 31)));
                end
                TOK_MB2, TOK_MB3, TOK_MB4: begin
                    len = (kind == TOK_MB2) ? 2 : (kind == TOK_MB3) ? 3 : 4;
                    str_q.push_back(lead_byte(len));
                    repeat (len - 1) str_q.push_back(cont_byte());
                end
                TOK_BROKEN: begin
                    len = $urandom_range(2, 4);
                    str_q.push_back(lead_byte(len));
                    repeat ($urandom_range(0, len - 2)) str_q.push_back(cont_byte());
                    b = 8'($urandom);
                    if (b[7:6] == 2'b10) b[6] = 1'b1;
                    str_q.push_back(b);
                end
                default: str_q.push_back(8'($urandom));
            endcase
        end
        // sometimes the string stops part way into a character
        if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(2, 4);
            str_q.push_back(lead_byte(len));
            repeat ($urandom_range(0, len - 2)) str_q.push_back(cont_byte());
        end
    endtask

    initial begin
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.in_last = 1'b0;
        out_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_gap_pct  = 20;
        drain_gap_pct = 20;
        // printable edges, doubled brace, control bytes, run closed at the end
        str_q = '{8'h20, 8'h7B, 8'h7E, 8'h00, 8'h1F, 8'h7F};
        send_string();
        // stray continuations and bad leads, run closed by a multi-byte character
        str_q = '{8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hC3, 8'hA9};
        send_string();
        // three and four byte characters, then an overlong two byte form
        str_q = '{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC0, 8'h80};
        send_string();
        // broken sequence: lead escaped, printable after it looked at again
        str_q = '{8'hE2, 8'h41};
        send_string();
        // string ends inside a character
        str_q = '{8'hF0, 8'h9F};
        send_string();

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_req  = 1;
                hold_done = 1;
            end
            if (items_sent >= QUIET_FROM) quiet = 1;
            case ($urandom_range(0, 3))
                0:       send_gap_pct = 0;
                1:       send_gap_pct = 10;
                default: send_gap_pct = 40;
            endcase
            case ($urandom_range(0, 3))
                0:       drain_gap_pct = 0;
                1:       drain_gap_pct = 10;
                default: drain_gap_pct = 40;
            endcase
            build_random_string();
            send_string();
        end
        in_if.valid <= 1'b0;

        while (sb.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_chars.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
